[design/text_console_writer_assert.svh]
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// property that must hold whenever the antecedent holds in the same cycle
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcw_pkg.sv]
// shared types, constants and helpers of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);

    // field widths
    localparam int OP_W   = 3;
    localparam int CH_W   = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // character codes
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TILDE = 8'h7E;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_MOVE  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_state;

    // column after a tab: next multiple of the tab stop above col
    function automatic logic [8:0] next_tab(input logic [COL_W-1:0] col);
        int k;
        logic [8:0] res;
        res = 9'(col);
        for (k = (COLUMNS + TAB_STOP - 1) / TAB_STOP; k >= 1; k--) begin
            if (k * TAB_STOP > int'(col)) res = 9'(k * TAB_STOP);
        end
        return res;
    endfunction

endpackage

[design/tcw_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/text_console_writer.sv]
// text console writer: cell store, cursor and put-char / scroll / clear sequencer
//
//  channel | dir | handshake                | payload
//  s       | in  | i_s_tvalid / o_s_tready  | tuser operation, tdata char,column,row
//  m       | out | o_m_tvalid / i_m_tready  | tdata cursor col,row,location,cell
//  cfg     | in  | i_cfg_valid / o_cfg_ready| attribute byte
//
// put char, move, write, clear request entry and unused codes answer in the cycle after the
// request; read answers after the registered ram read and the result register. a put char that
// scrolls stalls the input for one read-write pass over the cell store, then a blank bottom line;
// a clear stalls it while every cell is blanked. the result is issued when the request is taken, before the pass runs.
// reset clears cursor, attribute and control only: the cell store is undefined until written.
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // character[7:0], column[14:8], row[19:15], zero
    input  logic [OP_W-1:0]   i_s_tuser,   // operation[2:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                           // cursor_location[22:12], cell_data[38:23], zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    // state
    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [ATTR_W-1:0]   r_attr;
    logic [CELL_W-1:0]   r_blank, n_blank;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic                r_rd_ok, n_rd_ok;

    // ram ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [CELL_W-1:0]   ram_wdata, ram_rdata;

    // request fields
    logic [CH_W-1:0]     in_ch;
    logic [COL_W-1:0]    in_col1;
    logic [ROW_W-1:0]    in_row1;
    t_op                 in_op;
    logic                accept;

    assign in_ch   = i_s_tdata[7:0];
    assign in_col1 = i_s_tdata[14:8];
    assign in_row1 = i_s_tdata[19:15];
    assign in_op   = t_op'(i_s_tuser);
    assign accept  = i_s_tvalid && o_s_tready;

    // cursor address and location
    logic [ADDR_W-1:0]   cur_addr;
    logic [LOC_W-1:0]    cur_loc;
    assign cur_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col));
    assign cur_loc  = LOC_W'(LOC_W'(r_row) * LOC_W'(COLUMNS) + LOC_W'(r_col));

    // 1-based position check and address
    logic                pos_ok;
    logic [ADDR_W-1:0]   pos_addr;
    assign pos_ok = (in_col1 != '0) && (9'(in_col1) <= 9'(COLUMNS)) &&
                    (in_row1 != '0) && (7'(in_row1) <= 7'(ROWS));
    assign pos_addr = ADDR_W'(ADDR_W'(in_row1 - ROW_W'(1)) * ADDR_W'(COLUMNS) +
                              ADDR_W'(in_col1 - COL_W'(1)));

    // clamped move target
    logic [COL_W-1:0]    mv_col;
    logic [ROW_W-1:0]    mv_row;
    always_comb begin
        if (in_col1 == '0)                      mv_col = '0;
        else if (9'(in_col1) > 9'(COLUMNS))     mv_col = COL_W'(COLUMNS - 1);
        else                                    mv_col = in_col1 - COL_W'(1);
        if (in_row1 == '0)                      mv_row = '0;
        else if (7'(in_row1) > 7'(ROWS))        mv_row = ROW_W'(ROWS - 1);
        else                                    mv_row = in_row1 - ROW_W'(1);
    end

    // put char: cursor motion, cell write, wrap and scroll decision
    logic [8:0]          pc_col;
    logic [6:0]          pc_row;
    logic                pc_we;
    logic [ADDR_W-1:0]   pc_addr;
    logic [CELL_W-1:0]   pc_data;
    logic                pc_scroll;
    always_comb begin
        pc_col    = 9'(r_col);
        pc_row    = 7'(r_row);
        pc_we     = 1'b0;
        pc_addr   = cur_addr;
        pc_data   = {r_attr, in_ch};
        pc_scroll = 1'b0;
        if (in_ch == CH_BS) begin
            if (r_col != '0) begin
                pc_col  = 9'(r_col) - 9'd1;
                pc_we   = 1'b1;
                pc_addr = cur_addr - ADDR_W'(1);
                pc_data = {r_attr, CH_SPACE};
            end
        end else if (in_ch == CH_TAB) begin
            pc_col = next_tab(r_col);
        end else if (in_ch == CH_CR) begin
            pc_col = '0;
        end else if (in_ch == CH_LF) begin
            pc_col = '0;
            pc_row = 7'(r_row) + 7'd1;
        end else if (in_ch >= CH_SPACE && in_ch <= CH_TILDE) begin
            pc_we  = 1'b1;
            pc_col = 9'(r_col) + 9'd1;
        end
        if (pc_col >= 9'(COLUMNS)) begin
            pc_col = '0;
            pc_row = pc_row + 7'd1;
        end
        if (pc_row >= 7'(ROWS)) begin
            pc_row    = 7'(ROWS - 1);
            pc_scroll = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_READ)                   n_state = ST_READ;
                    else if (in_op == OP_CLEAR)             n_state = ST_FILL;
                    else if (in_op == OP_PUT && pc_scroll)  n_state = ST_SCROLL;
                end
            end
            ST_READ:   n_state = ST_IDLE;
            ST_SCROLL: if (r_idx == CNT_W'(CELLS - COLUMNS)) n_state = ST_FILL;
            ST_FILL:   if (r_idx == CNT_W'(CELLS - 1)) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs, ram control and register updates
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
        n_col       = r_col;
        n_row       = r_row;
        n_blank     = r_blank;
        n_idx       = r_idx;
        n_cell      = r_cell;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !i_m_tready;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = pc_data;
        ram_raddr   = pos_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cell  = '0;
                    n_rd_ok = pos_ok;
                    n_blank = {r_attr, CH_SPACE};
                    n_idx   = '0;
                    if (in_op != OP_READ) n_out_valid = 1'b1;
                    case (in_op)
                        OP_PUT: begin
                            n_col     = COL_W'(pc_col);
                            n_row     = ROW_W'(pc_row);
                            ram_we    = pc_we;
                            ram_waddr = pc_addr;
                        end
                        OP_CLEAR: begin
                            n_col = '0;
                            n_row = '0;
                        end
                        OP_MOVE: begin
                            n_col = mv_col;
                            n_row = mv_row;
                        end
                        OP_WRITE: begin
                            ram_we    = pos_ok;
                            ram_waddr = pos_addr;
                            ram_wdata = {r_attr, in_ch};
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_cell      = r_rd_ok ? ram_rdata : '0;
                n_out_valid = 1'b1;
            end
            ST_SCROLL: begin
                // read one line ahead, write the data in the next cycle one line up
                ram_raddr = ADDR_W'(r_idx + CNT_W'(COLUMNS));
                ram_we    = (r_idx != '0);
                ram_waddr = ADDR_W'(r_idx - CNT_W'(1));
                ram_wdata = ram_rdata;
                if (r_idx != CNT_W'(CELLS - COLUMNS)) n_idx = r_idx + CNT_W'(1);
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_idx);
                ram_wdata = r_blank;
                n_idx     = r_idx + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (i_cfg_valid && o_cfg_ready) r_attr <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_blank <= n_blank;
        r_cell  <= n_cell;
        r_rd_ok <= n_rd_ok;
    end

    // cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result: cursor fields come straight from the cursor registers
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_cell, cur_loc, r_row, r_col};

endmodule

[design/tcw_checker.sv]
// port-level checker for the text console writer and its bind
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [OP_W-1:0]   i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [39:0]       o_m_tdata
);

    // result held until taken
    `TCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")

    // location matches the reported cursor
    `TCW_ASSERT_SAME(a_loc, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[22:12] == 11'(int'(o_m_tdata[11:7]) * COLUMNS + int'(o_m_tdata[6:0])), "cursor location mismatch")

    // cursor stays on screen
    `TCW_ASSERT_SAME(a_range, i_clk, i_rst_n, o_m_tvalid, (int'(o_m_tdata[6:0]) < COLUMNS) && (int'(o_m_tdata[11:7]) < ROWS), "cursor off screen")

    // non-read request answered in the next cycle
    `TCW_ASSERT_NEXT(a_quick, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser != OP_READ), o_m_tvalid, "result missing after request")

    // read request answered after the registered ram read and the result register
    `TCW_ASSERT_NEXT(a_read, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser == OP_READ), !o_m_tvalid ##1 o_m_tvalid, "read result timing wrong")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
